// ===== hw/rtl/control_event_action_router_defines.svh =====
// ---------------------------------------------------------------------------
// Control event action router: assertion macros
// Shared concurrent assertion forms used by the router's engine.
// ---------------------------------------------------------------------------
`ifndef CONTROL_EVENT_ACTION_ROUTER_DEFINES_SVH
`define CONTROL_EVENT_ACTION_ROUTER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CEAR_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("control event action router: check failed");

// Next-cycle implication, disabled during reset.
`define CEAR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("control event action router: check failed");

`endif

// ===== hw/rtl/cear_pkg.sv =====
// ---------------------------------------------------------------------------
// Control event action router package
// Types, codes, control table and request decode shared by the router.
// ---------------------------------------------------------------------------
package cear_pkg;

  localparam int ACTION_SLOTS = 16;
  localparam int SLOT_W = (ACTION_SLOTS > 1) ? $clog2(ACTION_SLOTS) : 1;
  localparam int TIME_W = 64;
  localparam int WIN_W = 30;
  localparam int CODE_W = 6;
  localparam int ACT_W = 4;
  localparam int PHASE_W = 2;
  localparam int KIND_W = 2;

  localparam logic [PHASE_W-1:0] PHASE_TRIGGER = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_BEGIN = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_END = 2'd2;

  localparam logic [ACT_W-1:0] HOLD_ACTION = 4'd7;
  localparam logic [ACT_W-1:0] REPEAT_ACTION_RESET = 4'd10;

  localparam logic [CODE_W-1:0] EV_NONE = 6'd0;
  localparam logic [CODE_W-1:0] EV_TT_CW_ENGAGE = 6'd1;
  localparam logic [CODE_W-1:0] EV_TT_CW_RELEASE = 6'd2;
  localparam logic [CODE_W-1:0] EV_TT_CCW_ENGAGE = 6'd3;
  localparam logic [CODE_W-1:0] EV_TT_CCW_RELEASE = 6'd4;
  localparam logic [CODE_W-1:0] EV_LAST = 6'd32;

  localparam logic [1:0] CFG_PROFILE = 2'd0;
  localparam logic [1:0] CFG_HOLD_DEBOUNCE = 2'd1;
  localparam logic [1:0] CFG_REPEAT_INTERVAL = 2'd2;

  localparam logic [TIME_W-1:0] HOLD_DEBOUNCE_RESET = 64'd30000000;
  localparam logic [TIME_W-1:0] REPEAT_INTERVAL_RESET = 64'd100000000;

  localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TRIGGER = 2'd1;
  localparam logic [KIND_W-1:0] KIND_HOLD = 2'd2;
  localparam logic [KIND_W-1:0] KIND_TT_RELEASE = 2'd3;

  localparam logic [WIN_W-1:0] WIN_20MS = 30'd20000000;
  localparam logic [WIN_W-1:0] WIN_40MS = 30'd40000000;
  localparam logic [WIN_W-1:0] WIN_50MS = 30'd50000000;
  localparam logic [WIN_W-1:0] WIN_80MS = 30'd80000000;
  localparam logic [WIN_W-1:0] WIN_250MS = 30'd250000000;
  localparam logic [WIN_W-1:0] WIN_750MS = 30'd750000000;

  typedef struct packed {
    logic              profile;
    logic [TIME_W-1:0] hold_debounce;
    logic [TIME_W-1:0] repeat_interval;
  } cfg_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ACT_W-1:0]  action;
  } rom_entry_t;

  typedef struct packed {
    logic              mode;
    logic [CODE_W-1:0] code;
    logic [TIME_W-1:0] time_now;
    logic [KIND_W-1:0] kind;
    logic [ACT_W-1:0]  action;
    logic [WIN_W-1:0]  window;
    logic              press;
  } item_t;

  typedef struct packed {
    logic               valid;
    logic [ACT_W-1:0]   id;
    logic [PHASE_W-1:0] phase;
    logic [CODE_W-1:0]  src;
  } result_t;

  function automatic logic slot_ok(logic [ACT_W-1:0] action);
    return int'(action) < ACTION_SLOTS;
  endfunction

  function automatic logic [WIN_W-1:0] rom_window(logic [3:0] k);
    logic [WIN_W-1:0] w;
    case (k)
      4'd2: w = WIN_250MS;
      4'd3: w = WIN_750MS;
      4'd4: w = WIN_80MS;
      4'd5: w = WIN_50MS;
      4'd6: w = WIN_40MS;
      default: w = WIN_20MS;
    endcase
    return w;
  endfunction

  function automatic rom_entry_t rom_entry(logic [3:0] k, logic profile);
    rom_entry_t e;
    e.kind = KIND_TRIGGER;
    case (k)
      4'd0: e.action = 4'd10;
      4'd1: e.action = 4'd9;
      4'd2: e.action = 4'd0;
      4'd3: e.action = 4'd2;
      4'd4: e.action = 4'd4;
      4'd5: e.action = 4'd6;
      4'd6: e.action = 4'd1;
      4'd7: e.action = 4'd3;
      4'd8: e.action = 4'd5;
      4'd9: begin
        e.kind = profile ? KIND_TRIGGER : KIND_HOLD;
        e.action = profile ? 4'd8 : HOLD_ACTION;
      end
      4'd10: e.action = 4'd11;
      4'd11: e.action = 4'd12;
      4'd12: e.action = 4'd15;
      4'd13: e.action = 4'd13;
      4'd14: e.action = 4'd14;
      default: begin
        e.kind = profile ? KIND_HOLD : KIND_NONE;
        e.action = profile ? HOLD_ACTION : 4'd0;
      end
    endcase
    return e;
  endfunction

  function automatic item_t decode_item(logic mode, logic [CODE_W-1:0] code,
                                        logic [TIME_W-1:0] t, logic profile);
    item_t      it;
    rom_entry_t e;
    logic [3:0] k;
    k = 4'((code - 6'd1) >> 1);
    e = rom_entry(k, profile);
    it.mode = mode;
    it.code = code;
    it.time_now = t;
    it.action = e.action;
    it.window = rom_window(k);
    it.press = code[0];
    if (mode) begin
      it.kind = KIND_NONE;
    end else if (code == EV_TT_CW_RELEASE || code == EV_TT_CCW_RELEASE) begin
      it.kind = KIND_TT_RELEASE;
    end else if (code == EV_NONE || code > EV_LAST) begin
      it.kind = KIND_NONE;
    end else if (e.kind == KIND_TRIGGER && (!code[0] || !slot_ok(e.action))) begin
      it.kind = KIND_NONE;
    end else begin
      it.kind = e.kind;
    end
    return it;
  endfunction

endpackage

// ===== hw/rtl/cear_ram.sv =====
// ---------------------------------------------------------------------------
// Router RAM
// Simple dual-port memory with one write port and a registered read port.
// ---------------------------------------------------------------------------
module cear_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/cear_engine.sv =====
// ---------------------------------------------------------------------------
// Router action engine
// Second stage: trigger debounce against the last-time memory, auto-repeat
// and hold tracking, and selection of the single action per request.
// ---------------------------------------------------------------------------
`include "control_event_action_router_defines.svh"

module cear_engine import cear_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    in_valid,
  input  item_t   in_item,
  input  logic    out_free,
  output logic    in_ready,
  output result_t result
);

  logic              accept;
  logic              fire;
  logic              s1_valid;
  item_t             s1;
  logic [SLOT_W-1:0] s1_slot;
  logic [TIME_W-1:0] rd_data;
  logic [TIME_W-1:0] last_time;

  logic              fwd_valid;
  logic [SLOT_W-1:0] fwd_addr;
  logic [TIME_W-1:0] fwd_data;

  logic [ACTION_SLOTS-1:0] seen;

  logic              hold_on, hold_on_next;
  logic              pend, pend_next;
  logic              pend_val, pend_val_next;
  logic [TIME_W-1:0] pend_since, pend_since_next;
  logic [CODE_W-1:0] pend_src, pend_src_next;
  logic              rep_on, rep_on_next;
  logic [ACT_W-1:0]  rep_id, rep_id_next;
  logic [CODE_W-1:0] rep_src, rep_src_next;
  logic [TIME_W-1:0] rep_time, rep_time_next;

  logic              wr_req;
  logic [SLOT_W-1:0] wr_slot;
  logic              wr_en;
  result_t           res;

  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] sat;
  logic [TIME_W:0]   hold_diff;
  logic [TIME_W:0]   trig_diff;
  logic              hold_due;
  logic              rep_due;
  logic              blocked;
  logic              engage;

  assign accept = in_valid && in_ready;
  assign fire = s1_valid && (!res.valid || out_free);
  assign in_ready = !s1_valid || fire;
  assign s1_slot = SLOT_W'(s1.action);
  assign wr_en = fire && wr_req;

  cear_ram #(
    .DEPTH (ACTION_SLOTS),
    .WIDTH (TIME_W)
  ) u_last_time (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_slot),
    .wdata (s1.time_now),
    .re    (accept),
    .raddr (SLOT_W'(in_item.action)),
    .rdata (rd_data)
  );

  // The read issued alongside the previous write sees stale data.
  assign last_time = (fwd_valid && fwd_addr == s1_slot) ? fwd_data : rd_data;

  assign sum = {1'b0, s1.time_now} + {1'b0, cfg.repeat_interval};
  assign sat = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
  assign hold_diff = {1'b0, s1.time_now} - {1'b0, pend_since};
  assign trig_diff = {1'b0, s1.time_now} - {1'b0, last_time};
  assign hold_due = pend && !hold_diff[TIME_W] && hold_diff[TIME_W-1:0] >= cfg.hold_debounce;
  assign rep_due = rep_on && s1.time_now >= rep_time;
  assign blocked = seen[s1_slot] &&
                   (trig_diff[TIME_W] || trig_diff[TIME_W-1:0] < TIME_W'(s1.window));
  assign engage = s1.code == EV_TT_CW_ENGAGE || s1.code == EV_TT_CCW_ENGAGE;

  always_comb begin
    hold_on_next = hold_on;
    pend_next = pend;
    pend_val_next = pend_val;
    pend_since_next = pend_since;
    pend_src_next = pend_src;
    rep_on_next = rep_on;
    rep_id_next = rep_id;
    rep_src_next = rep_src;
    rep_time_next = rep_time;
    wr_req = 1'b0;
    wr_slot = s1_slot;
    res = '0;
    if (s1_valid) begin
      if (s1.mode) begin
        if (hold_due) begin
          hold_on_next = pend_val;
          pend_next = 1'b0;
          res.valid = 1'b1;
          res.id = HOLD_ACTION;
          res.phase = pend_val ? PHASE_BEGIN : PHASE_END;
          res.src = pend_src;
        end else if (rep_due) begin
          rep_time_next = sat;
          wr_req = slot_ok(rep_id);
          wr_slot = SLOT_W'(rep_id);
          res.valid = 1'b1;
          res.id = rep_id;
          res.phase = PHASE_TRIGGER;
          res.src = rep_src;
        end
      end else begin
        case (s1.kind)
          KIND_TT_RELEASE: begin
            if (rep_on && rep_src == s1.code - 6'd1) begin
              rep_on_next = 1'b0;
              rep_src_next = EV_NONE;
              rep_time_next = '0;
            end
          end
          KIND_TRIGGER: begin
            if (engage) begin
              rep_on_next = 1'b1;
              rep_id_next = s1.action;
              rep_src_next = s1.code;
              rep_time_next = sat;
            end
            if (!blocked) begin
              wr_req = 1'b1;
              res.valid = 1'b1;
              res.id = s1.action;
              res.phase = PHASE_TRIGGER;
              res.src = s1.code;
            end
          end
          KIND_HOLD: begin
            if (s1.press == hold_on) begin
              if (pend && pend_val != s1.press) begin
                pend_next = 1'b0;
              end
            end else if (!pend || pend_val != s1.press) begin
              pend_next = 1'b1;
              pend_val_next = s1.press;
              pend_since_next = s1.time_now;
              pend_src_next = s1.code;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    result = res;
    result.valid = res.valid && fire;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (fire) begin
      fwd_valid <= wr_req;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_addr <= wr_slot;
      fwd_data <= s1.time_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else if (wr_en) begin
      seen[wr_slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_on <= 1'b0;
      pend <= 1'b0;
      pend_val <= 1'b0;
      pend_since <= '0;
      pend_src <= EV_NONE;
      rep_on <= 1'b0;
      rep_id <= REPEAT_ACTION_RESET;
      rep_src <= EV_NONE;
      rep_time <= '0;
    end else if (fire) begin
      hold_on <= hold_on_next;
      pend <= pend_next;
      pend_val <= pend_val_next;
      pend_since <= pend_since_next;
      pend_src <= pend_src_next;
      rep_on <= rep_on_next;
      rep_id <= rep_id_next;
      rep_src <= rep_src_next;
      rep_time <= rep_time_next;
    end
  end

  `CEAR_ASSERT_IMPL(a_result_room, clk, rst, result.valid, out_free)
  `CEAR_ASSERT_IMPL(a_fwd_seen, clk, rst, fwd_valid, seen[fwd_addr])
  `CEAR_ASSERT_NEXT(a_hold_cleared, clk, rst, result.valid && result.phase != PHASE_TRIGGER, !pend)
  `CEAR_ASSERT_NEXT(a_repeat_started, clk, rst,
                    fire && !s1.mode && s1.kind == KIND_TRIGGER && engage, rep_on)

endmodule

// ===== hw/rtl/control_event_action_router.sv =====
// ---------------------------------------------------------------------------
// Control event action router
// Path: a request is registered in the engine stage, and its action is then registered on the output.
// Throughput: one request per cycle, unless an action waits on a stalled output.
// Reset: synchronous; clears all control state at once, no memory clearing pass.
// ---------------------------------------------------------------------------
module control_event_action_router import cear_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // event_code[5:0], time_now[69:6], zero pad
  input  logic [0:0]  s_axis_tuser,   // mode[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // action_id[3:0], action_phase[5:4],
                                      // source_event[11:6], zero pad
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  cfg_t    cfg;
  item_t   in_item;
  result_t result;
  logic    out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.profile <= 1'b0;
      cfg.hold_debounce <= HOLD_DEBOUNCE_RESET;
      cfg.repeat_interval <= REPEAT_INTERVAL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PROFILE: cfg.profile <= cfg_data[0];
        CFG_HOLD_DEBOUNCE: cfg.hold_debounce <= cfg_data;
        CFG_REPEAT_INTERVAL: cfg.repeat_interval <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_item = decode_item(s_axis_tuser[0], s_axis_tdata[5:0], s_axis_tdata[69:6],
                               cfg.profile);
  assign out_free = !m_axis_tvalid || m_axis_tready;

  cear_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_axis_tvalid),
    .in_item  (in_item),
    .out_free (out_free),
    .in_ready (s_axis_tready),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (result.valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.valid) begin
      m_axis_tdata <= {4'd0, result.src, result.phase, result.id};
    end
  end

endmodule

// ===== tb/cear_action_checker.sv =====
// ---------------------------------------------------------------------------
// Control event action router: action checker
// Watches the request, result and register ports of the router. It keeps its
// own model of the control table, debounce, hold and auto-repeat state. It
// queues the action that each accepted request should raise, and compares
// every accepted result field by field with the oldest queued action.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module cear_action_checker import cear_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // event_code[5:0], time_now[69:6], zero pad
  input  logic [0:0]  s_axis_tuser,   // mode[0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,   // action_id[3:0], action_phase[5:4],
                                      // source_event[11:6], zero pad
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          errors,
  output int          checked,
  output int          outstanding
);

  typedef struct packed {
    logic [ACT_W-1:0]   id;
    logic [PHASE_W-1:0] phase;
    logic [CODE_W-1:0]  src;
  } action_t;

  action_t expected_actions[$];
  int      error_count;
  int      checked_count;

  logic              profile;
  logic [TIME_W-1:0] hold_debounce;
  logic [TIME_W-1:0] repeat_interval;

  logic              trig_seen [ACTION_SLOTS];
  logic [TIME_W-1:0] trig_time [ACTION_SLOTS];
  logic              hold_on;
  logic              hold_armed;
  logic              pending_value;
  logic [TIME_W-1:0] pending_since;
  logic [CODE_W-1:0] pending_src;
  logic              repeat_on;
  logic [ACT_W-1:0]  repeat_id;
  logic [CODE_W-1:0] repeat_src;
  logic [TIME_W-1:0] repeat_next;

  initial begin
    error_count = 0;
    checked_count = 0;
  end

  function automatic logic [TIME_W-1:0] add_sat(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
  endfunction

  function automatic logic [TIME_W-1:0] debounce_window(input logic [3:0] k);
    logic [TIME_W-1:0] w;
    case (k)
      4'd2: w = 64'd250_000_000;
      4'd3: w = 64'd750_000_000;
      4'd4: w = 64'd80_000_000;
      4'd5: w = 64'd50_000_000;
      4'd6: w = 64'd40_000_000;
      default: w = 64'd20_000_000;
    endcase
    return w;
  endfunction

  function automatic logic [KIND_W-1:0] control_kind(input logic [3:0] k,
                                                     input logic prof);
    if (k == 4'd9) return prof ? KIND_TRIGGER : KIND_HOLD;
    if (k == 4'd15) return prof ? KIND_HOLD : KIND_NONE;
    return KIND_TRIGGER;
  endfunction

  function automatic logic [ACT_W-1:0] control_action(input logic [3:0] k,
                                                      input logic prof);
    logic [ACT_W-1:0] a;
    case (k)
      4'd0: a = 4'd10;
      4'd1: a = 4'd9;
      4'd2: a = 4'd0;
      4'd3: a = 4'd2;
      4'd4: a = 4'd4;
      4'd5: a = 4'd6;
      4'd6: a = 4'd1;
      4'd7: a = 4'd3;
      4'd8: a = 4'd5;
      4'd9: a = prof ? 4'd8 : HOLD_ACTION;
      4'd10: a = 4'd11;
      4'd11: a = 4'd12;
      4'd12: a = 4'd15;
      4'd13: a = 4'd13;
      4'd14: a = 4'd14;
      default: a = HOLD_ACTION;
    endcase
    return a;
  endfunction

  // Advances the model by one request; returns 1 when an action is raised.
  function automatic logic route_request(input logic mode,
                                         input logic [CODE_W-1:0] code,
                                         input logic [TIME_W-1:0] t,
                                         output action_t act);
    logic [CODE_W-1:0] offset;
    logic [3:0]        k;
    logic              press;
    logic [KIND_W-1:0] kind;
    logic [ACT_W-1:0]  id;
    act = '0;
    if (mode) begin
      // A hold change that is due takes precedence over a due repeat.
      if (hold_armed && t >= pending_since && t - pending_since >= hold_debounce) begin
        hold_on = pending_value;
        hold_armed = 1'b0;
        act.id = HOLD_ACTION;
        act.phase = pending_value ? PHASE_BEGIN : PHASE_END;
        act.src = pending_src;
        return 1'b1;
      end
      if (!repeat_on || t < repeat_next) return 1'b0;
      repeat_next = add_sat(t, repeat_interval);
      if (int'(repeat_id) < ACTION_SLOTS) begin
        trig_seen[repeat_id] = 1'b1;
        trig_time[repeat_id] = t;
      end
      act.id = repeat_id;
      act.phase = PHASE_TRIGGER;
      act.src = repeat_src;
      return 1'b1;
    end
    if (code == EV_TT_CW_RELEASE || code == EV_TT_CCW_RELEASE) begin
      if (repeat_on && repeat_src == code - 6'd1) begin
        repeat_on = 1'b0;
        repeat_src = EV_NONE;
        repeat_next = '0;
      end
      return 1'b0;
    end
    if (code == EV_NONE || code > EV_LAST) return 1'b0;
    offset = code - 6'd1;
    k = offset[4:1];
    press = code[0];
    kind = control_kind(k, profile);
    id = control_action(k, profile);
    if (kind == KIND_NONE) return 1'b0;
    if (kind == KIND_TRIGGER) begin
      if (!press || int'(id) >= ACTION_SLOTS) return 1'b0;
      if (code == EV_TT_CW_ENGAGE || code == EV_TT_CCW_ENGAGE) begin
        repeat_on = 1'b1;
        repeat_id = id;
        repeat_src = code;
        repeat_next = add_sat(t, repeat_interval);
      end
      if (trig_seen[id] && (t < trig_time[id] || t - trig_time[id] < debounce_window(k)))
        return 1'b0;
      trig_seen[id] = 1'b1;
      trig_time[id] = t;
      act.id = id;
      act.phase = PHASE_TRIGGER;
      act.src = code;
      return 1'b1;
    end
    // Hold control: a reversal before the change is emitted cancels it.
    if (press == hold_on) begin
      if (hold_armed && pending_value != press) hold_armed = 1'b0;
      return 1'b0;
    end
    if (!hold_armed || pending_value != press) begin
      hold_armed = 1'b1;
      pending_value = press;
      pending_since = t;
      pending_src = code;
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    action_t got;
    action_t want;
    action_t predicted;
    if (rst) begin
      expected_actions.delete();
      profile = 1'b0;
      hold_debounce = HOLD_DEBOUNCE_RESET;
      repeat_interval = REPEAT_INTERVAL_RESET;
      for (int i = 0; i < ACTION_SLOTS; i++) begin
        trig_seen[i] = 1'b0;
        trig_time[i] = '0;
      end
      hold_on = 1'b0;
      hold_armed = 1'b0;
      pending_value = 1'b0;
      pending_since = '0;
      pending_src = EV_NONE;
      repeat_on = 1'b0;
      repeat_id = REPEAT_ACTION_RESET;
      repeat_src = EV_NONE;
      repeat_next = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PROFILE: profile = cfg_data[0];
          CFG_HOLD_DEBOUNCE: hold_debounce = cfg_data;
          CFG_REPEAT_INTERVAL: repeat_interval = cfg_data;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.id = m_axis_tdata[3:0];
        got.phase = m_axis_tdata[5:4];
        got.src = m_axis_tdata[11:6];
        if (expected_actions.size() == 0) begin
          $display("%0t: unexpected action, expected none, got id %0d phase %0d src %0d",
                   $time, got.id, got.phase, got.src);
          error_count++;
        end else begin
          want = expected_actions.pop_front();
          checked_count++;
          if (got.id !== want.id || got.phase !== want.phase || got.src !== want.src) begin
            $display("%0t: action mismatch, expected %0d/%0d/%0d, got %0d/%0d/%0d (id/phase/src)",
                     $time, want.id, want.phase, want.src, got.id, got.phase, got.src);
            error_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (route_request(s_axis_tuser[0], s_axis_tdata[5:0], s_axis_tdata[69:6], predicted))
          expected_actions.push_back(predicted);
      end
    end
    errors <= error_count;
    checked <= checked_count;
    outstanding <= expected_actions.size();
  end

endmodule

// ===== tb/tb_control_event_action_router.sv =====
// ---------------------------------------------------------------------------
// Control event action router testbench
// Drives timestamped control events and ticks with random pacing on both
// streams, first a directed sequence and then random phases under several
// register settings, including a long output stall. The checker alongside
// the router predicts and compares every action.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_control_event_action_router;
  import cear_pkg::*;

  localparam logic MODE_EVENT = 1'b0;
  localparam logic MODE_TICK = 1'b1;
  localparam logic [63:0] MS = 64'd1_000_000;
  localparam logic [63:0] T_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_STALL = 300;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;   // event_code[5:0], time_now[69:6], zero pad
  logic [0:0]  s_axis_tuser;   // mode[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // action_id[3:0], action_phase[5:4],
                               // source_event[11:6], zero pad
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  int failures;
  int compared;
  int in_flight;
  int quiet_cycles = 0;

  logic        stall_request = 1'b0;
  logic        sink_always_ready = 1'b0;
  logic        sender_paced = 1'b1;
  logic        cur_profile = 1'b0;
  logic [63:0] stamp_ns = '0;
  int          n_requests = 0;
  int          n_ticks = 0;
  int          n_settings = 1;

  always #2 clk = ~clk;

  control_event_action_router u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  cear_action_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .errors        (failures),
    .checked       (compared),
    .outstanding   (in_flight)
  );

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Mostly short pauses, now and then a long one.
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] advance_clock();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) stamp_ns = stamp_ns + $urandom_range(0, 5_000_000);
    else if (r < 70) stamp_ns = stamp_ns + $urandom_range(5_000_000, 60_000_000);
    else if (r < 88) stamp_ns = stamp_ns + $urandom_range(60_000_000, 400_000_000);
    else if (r < 93) stamp_ns = stamp_ns + $urandom_range(400_000_000, 1_000_000_000);
    else if (r < 97) stamp_ns = stamp_ns - $urandom_range(0, 100_000_000);
    else if (r < 98) stamp_ns = {$urandom, $urandom};
    else if (r < 99) stamp_ns = T_MAX - $urandom_range(0, 200_000_000);
    else stamp_ns = 64'($urandom_range(0, 1000));
    return stamp_ns;
  endfunction

  // Receiver: random pauses, a free-running mode, and one long hold-off.
  initial begin
    int gap;
    gap = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_request) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_STALL) @(negedge clk);
        stall_request = 1'b0;
      end else if (sink_always_ready) begin
        m_axis_tready <= 1'b1;
      end else if (gap > 0) begin
        m_axis_tready <= 1'b0;
        gap--;
      end else begin
        m_axis_tready <= 1'b1;
        gap = idle_length();
      end
    end
  end

  task automatic send_request(input logic mode, input logic [CODE_W-1:0] code,
                              input logic [63:0] t);
    int gap;
    gap = sender_paced ? idle_length() : 0;
    if (gap > 0) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= mode;
    s_axis_tdata <= {2'b00, t, code};
    do @(posedge clk); while (!s_axis_tready);
    n_requests++;
    if (mode) n_ticks++;
  endtask

  task automatic random_request();
    int          r;
    int          k;
    logic [5:0]  code;
    logic [63:0] t;
    r = $urandom_range(0, 99);
    t = advance_clock();
    k = $urandom_range(0, 15);
    if (r < 30) begin
      send_request(MODE_TICK, 6'($urandom_range(0, 63)), t);
    end else begin
      if (r < 55) code = 6'(2 * k + 1);
      else if (r < 65) code = 6'(2 * k + 2);
      else if (r < 80) code = (cur_profile ? 6'd31 : 6'd19) + 6'($urandom_range(0, 1));
      else if (r < 92) code = 6'($urandom_range(1, 4));
      else begin
        code = 6'($urandom_range(32, 63));
        if (code == EV_LAST) code = EV_NONE;
      end
      send_request(MODE_EVENT, code, t);
    end
  endtask

  task automatic run_random(input int count);
    repeat (count) random_request();
  endtask

  // Waits until every predicted action has come out, then lets requests that
  // raise no action leave the pipeline.
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (in_flight != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_settings(input logic prof, input logic [63:0] hold_ns,
                                input logic [63:0] repeat_ns);
    drain();
    write_reg(CFG_PROFILE, {63'd0, prof});
    write_reg(CFG_HOLD_DEBOUNCE, hold_ns);
    write_reg(CFG_REPEAT_INTERVAL, repeat_ns);
    cur_profile = prof;
    n_settings++;
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_PROFILE;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: unknown codes, debounce, holds, repeat and saturation.
    send_request(MODE_TICK, 6'd63, 64'd0);
    send_request(MODE_EVENT, EV_NONE, 64'd0);
    send_request(MODE_EVENT, 6'd5, 64'd1000);
    send_request(MODE_EVENT, 6'd5, 64'd1000 + 250 * MS - 1);
    send_request(MODE_EVENT, 6'd5, 64'd1000 + 250 * MS);
    send_request(MODE_EVENT, 6'd5, 64'd500);
    send_request(MODE_EVENT, 6'd6, 600 * MS);
    send_request(MODE_EVENT, 6'd31, 700 * MS);
    send_request(MODE_EVENT, 6'd19, 1000 * MS);
    send_request(MODE_TICK, EV_NONE, 1030 * MS - 1);
    send_request(MODE_TICK, EV_NONE, 1030 * MS);
    send_request(MODE_EVENT, 6'd20, 2000 * MS);
    send_request(MODE_EVENT, 6'd19, 2001 * MS);
    send_request(MODE_TICK, EV_NONE, 3000 * MS);
    send_request(MODE_EVENT, 6'd20, 5000 * MS);
    send_request(MODE_TICK, EV_NONE, 4000 * MS);
    send_request(MODE_TICK, EV_NONE, 5030 * MS);
    send_request(MODE_EVENT, EV_TT_CW_ENGAGE, 6000 * MS);
    send_request(MODE_EVENT, 6'd19, 6050 * MS);
    send_request(MODE_TICK, EV_NONE, 6200 * MS);
    send_request(MODE_TICK, EV_NONE, 6200 * MS);
    send_request(MODE_EVENT, EV_TT_CCW_RELEASE, 6300 * MS);
    send_request(MODE_TICK, EV_NONE, 6400 * MS);
    send_request(MODE_EVENT, EV_TT_CW_RELEASE, 6500 * MS);
    send_request(MODE_TICK, EV_NONE, 7000 * MS);
    send_request(MODE_EVENT, EV_TT_CCW_ENGAGE, T_MAX - 10);
    send_request(MODE_TICK, EV_NONE, T_MAX);
    send_request(MODE_EVENT, EV_TT_CCW_RELEASE, T_MAX);

    stamp_ns = 8000 * MS;
    apply_settings(1'b1, 64'd0, 64'd0);
    run_random(300);

    apply_settings(1'b0, T_MAX, T_MAX);
    run_random(300);

    // Long output stall while requests keep coming, so the router backs up.
    apply_settings(1'b1, 30 * MS, 100 * MS);
    sender_paced = 1'b0;
    stall_request = 1'b1;
    repeat (60) begin
      stamp_ns = stamp_ns + 800 * MS;
      send_request(MODE_EVENT, 6'(2 * $urandom_range(0, 14) + 1), stamp_ns);
    end
    sender_paced = 1'b1;
    run_random(300);

    apply_settings(1'b0, 5 * MS, 17 * MS);
    sender_paced = 1'b0;
    sink_always_ready = 1'b1;
    run_random(300);
    sender_paced = 1'b1;
    sink_always_ready = 1'b0;

    apply_settings(1'b1, 64'($urandom_range(0, 200_000_000)),
                   64'($urandom_range(1_000_000, 200_000_000)));
    run_random(300);

    apply_settings(1'b0, 30 * MS, 1 * MS);
    run_random(300);

    drain();
    $display("Covered %0d requests (%0d ticks) under %0d register settings, one long stall.",
             n_requests, n_ticks, n_settings);
    $display("%0d actions compared, %0d mismatches.", compared, failures);
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/cear_pkg.sv
hw/rtl/cear_ram.sv
hw/rtl/cear_engine.sv
hw/rtl/control_event_action_router.sv
tb/cear_action_checker.sv
tb/tb_control_event_action_router.sv
